// ===== hw/rtl/bb3_pkg.sv =====
// bb3_pkg: shared constants, types and helper functions of the 3x3 box blur
// used by every module of the block, depends on nothing

package bb3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int CHAN_W       = 8;
  localparam int CHANS        = 3;
  localparam int SLOTS        = 3;
  localparam int PIX_W        = CHANS * CHAN_W;
  localparam int SUM_W        = 12;
  localparam int COLSUM_W     = 10;
  localparam int N_W          = 4;
  localparam int NUM_W        = SUM_W + 1;
  localparam int RECIP_W      = 18;
  localparam int RECIP_SHIFT  = 18;
  localparam int PROD_W       = NUM_W + RECIP_W;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef logic [1:0]                   slot_t;
  typedef logic [PIX_W-1:0]             pix_t;
  typedef logic [SLOTS-1:0][PIX_W-1:0]  col_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    slot_t            slot;
    pix_t             data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic                        valid;
    logic [CHANS-1:0][SUM_W-1:0] sum;
    logic [N_W-1:0]              n;
    logic                        row_end;
    logic                        frame_end;
  } mean_req_t;

  // ceil(2^18 / (2n)) for the pixel counts a 3x3 window can hold
  function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd6:    r = 18'd21846;
      4'd9:    r = 18'd14564;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  // residue mod 3 from base-4 digits
  function automatic slot_t mod3(input logic [ROW_W-1:0] v);
    logic [2:0] acc;
    acc = 3'd0;
    for (int i = 0; i < ROW_W / 2; i++) begin
      acc = acc + {1'b0, v[2*i +: 2]};
      if (acc >= 3'd3) begin
        acc = acc - 3'd3;
      end
    end
    return acc[1:0];
  endfunction

endpackage

// ===== hw/rtl/bb3_line_store.sv =====
// bb3_line_store: three line stores packed side by side, one column per word
// one lane write port and one registered read port; depends on bb3_pkg

module bb3_line_store import bb3_pkg::*; (
  input  logic    clk_i,
  input  mem_wr_t wr_i,
  input  mem_rd_t rd_i,
  output col_t    rd_data_o
);

  col_t mem_q [MAX_WIDTH];
  col_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr][wr_i.slot] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/bb3_mean.sv =====
// bb3_mean: rounded mean by reciprocal multiply, then a two-entry output queue
// depends on bb3_pkg

module bb3_mean import bb3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mean_req_t         req_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CHAN_W-1:0] red_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] blue_out_o,
  output logic              row_end_o,
  output logic              frame_end_o
);

  typedef struct packed {
    logic [CHANS-1:0][CHAN_W-1:0] chan;
    logic                         row_end;
    logic                         frame_end;
  } res_t;

  logic                         pipe_valid_q;
  logic [CHANS-1:0][PROD_W-1:0] prod_q;
  logic                         row_end_q;
  logic                         frame_end_q;
  logic [CHANS-1:0][PROD_W-1:0] prod_d;
  logic [NUM_W-1:0]             num;
  res_t                         push_res;
  res_t                         ent_q [2];
  logic                         wptr_q;
  logic                         rptr_q;
  logic [1:0]                   cnt_q;
  logic                         pop;

  always_comb begin
    prod_d = '0;
    for (int ch = 0; ch < CHANS; ch++) begin
      num = {req_i.sum[ch], 1'b0} + NUM_W'(req_i.n);
      prod_d[ch] = PROD_W'(num) * PROD_W'(recip(req_i.n));
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_q      <= prod_d;
      row_end_q   <= req_i.row_end;
      frame_end_q <= req_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else begin
      pipe_valid_q <= req_i.valid;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANS; ch++) begin
      push_res.chan[ch] = prod_q[ch][RECIP_SHIFT +: CHAN_W];
    end
    push_res.row_end   = row_end_q;
    push_res.frame_end = frame_end_q;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (pipe_valid_q) begin
      ent_q[wptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (pipe_valid_q) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, pipe_valid_q} - {1'b0, pop};
    end
  end

  assign red_out_o   = ent_q[rptr_q].chan[0];
  assign green_out_o = ent_q[rptr_q].chan[1];
  assign blue_out_o  = ent_q[rptr_q].chan[2];
  assign row_end_o   = ent_q[rptr_q].row_end;
  assign frame_end_o = ent_q[rptr_q].frame_end;

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// bb3_ctrl: frame registers, raster counters and the read-accumulate sequencer
// drives the line store and the mean unit; depends on bb3_pkg

module bb3_ctrl import bb3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [CHAN_W-1:0]     red_in_i,
  input  logic [CHAN_W-1:0]     green_in_i,
  input  logic [CHAN_W-1:0]     blue_in_i,
  input  logic                  out_beat_i,
  output mem_wr_t               mem_wr_o,
  output mem_rd_t               mem_rd_o,
  input  col_t                  mem_rd_data_i,
  output mean_req_t             mean_req_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_READ   = 3'b010,
    ST_LAUNCH = 3'b100
  } state_e;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [COL_W-1:0]        w_last;
  logic [ROW_W-1:0]        h_last;

  state_e                      state_q, state_d;
  logic [ROW_W-1:0]            row_q, row_d;
  logic [COL_W-1:0]            col_q, col_d;
  slot_t                       rslot_q, rslot_d;
  logic [COL_W-1:0]            dcol_q, dcol_d;
  logic [COL_W-1:0]            x_q, x_d;
  logic                        second_q, second_d;
  logic                        drain_q, drain_d;
  slot_t                       top_q, top_d;
  slot_t                       mid_q, mid_d;
  slot_t                       bot_q, bot_d;
  logic                        top_v_q, top_v_d;
  logic                        bot_v_q, bot_v_d;
  logic [1:0]                  k_q, k_d;
  logic                        tag_q, tag_d;
  logic [CHANS-1:0][SUM_W-1:0] acc_q, acc_d;
  logic [1:0]                  ncols_q, ncols_d;
  logic [1:0]                  inflight_q, inflight_d;

  logic                           in_beat;
  logic                           has_first;
  logic                           has_second;
  slot_t                          hs;
  logic [COL_W:0]                 xa;
  logic [COL_W:0]                 xm1;
  logic                           col_ok;
  logic [1:0]                     nrows;
  logic [CHANS-1:0][COLSUM_W-1:0] colsum;

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (width_q > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end
  end

  assign w_last = COL_W'(w_eff - WIDTH_REG_W'(1));
  assign h_last = ROW_W'(h_eff - HEIGHT_REG_W'(1));
  assign hs     = mod3(h_last);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign has_first  = (row_q != '0) && (col_q != '0);
  assign has_second = (row_q != '0) && (col_q == w_last);

  // column sum over the rows of the window that lie inside the frame
  always_comb begin
    for (int ch = 0; ch < CHANS; ch++) begin
      colsum[ch] = COLSUM_W'(mem_rd_data_i[mid_q][PIX_W-1-CHAN_W*ch -: CHAN_W])
                 + (top_v_q ? COLSUM_W'(mem_rd_data_i[top_q][PIX_W-1-CHAN_W*ch -: CHAN_W])
                            : COLSUM_W'(0))
                 + (bot_v_q ? COLSUM_W'(mem_rd_data_i[bot_q][PIX_W-1-CHAN_W*ch -: CHAN_W])
                            : COLSUM_W'(0));
    end
  end

  assign xa     = {1'b0, x_q} + (COL_W+1)'(k_q);
  assign xm1    = xa - (COL_W+1)'(1);
  assign col_ok = (k_q != 2'd3) && (xa != '0) && (xm1 <= {1'b0, w_last});
  assign nrows  = 2'd1 + {1'b0, top_v_q} + {1'b0, bot_v_q};

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    rslot_d    = rslot_q;
    dcol_d     = dcol_q;
    x_d        = x_q;
    second_d   = second_q;
    drain_d    = drain_q;
    top_d      = top_q;
    mid_d      = mid_q;
    bot_d      = bot_q;
    top_v_d    = top_v_q;
    bot_v_d    = bot_v_q;
    k_d        = k_q;
    tag_d      = tag_q;
    acc_d      = acc_q;
    ncols_d    = ncols_q;
    mem_wr_o   = '0;
    mem_rd_o   = '0;
    mean_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          k_d = 2'd0;
          if (op_e'(op_i) == OP_PIXEL) begin
            mem_wr_o.en   = 1'b1;
            mem_wr_o.addr = col_q;
            mem_wr_o.slot = rslot_q;
            mem_wr_o.data = {red_in_i, green_in_i, blue_in_i};
            x_d      = has_first ? col_q - COL_W'(1) : w_last;
            second_d = has_first && has_second;
            drain_d  = 1'b0;
            top_d    = slot_inc(rslot_q);
            mid_d    = slot_inc(slot_inc(rslot_q));
            bot_d    = rslot_q;
            top_v_d  = (row_q > ROW_W'(1));
            bot_v_d  = 1'b1;
            if (has_first || has_second) begin
              state_d = ST_READ;
            end
            if (col_q == w_last) begin
              col_d = '0;
              if (row_q == h_last) begin
                row_d   = '0;
                rslot_d = 2'd0;
              end else begin
                row_d   = row_q + ROW_W'(1);
                rslot_d = slot_inc(rslot_q);
              end
            end else begin
              col_d = col_q + COL_W'(1);
            end
          end else begin
            x_d      = dcol_q;
            second_d = 1'b0;
            drain_d  = 1'b1;
            top_d    = slot_inc(slot_inc(hs));
            mid_d    = hs;
            bot_d    = hs;
            top_v_d  = (h_last != '0);
            bot_v_d  = 1'b0;
            state_d  = ST_READ;
            dcol_d   = (dcol_q == w_last) ? '0 : dcol_q + COL_W'(1);
          end
        end
      end
      ST_READ: begin
        mem_rd_o.en   = col_ok;
        mem_rd_o.addr = xm1[COL_W-1:0];
        tag_d         = col_ok;
        if (k_q == 2'd0) begin
          acc_d   = '0;
          ncols_d = 2'd0;
        end else if (tag_q) begin
          for (int ch = 0; ch < CHANS; ch++) begin
            acc_d[ch] = acc_q[ch] + SUM_W'(colsum[ch]);
          end
          ncols_d = ncols_q + 2'd1;
        end
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (inflight_q != 2'd2) begin
          mean_req_o.valid     = 1'b1;
          mean_req_o.sum       = acc_q;
          mean_req_o.n         = N_W'(nrows) * N_W'(ncols_q);
          mean_req_o.row_end   = (x_q == w_last);
          mean_req_o.frame_end = drain_q && (x_q == w_last);
          if (second_q) begin
            second_d = 1'b0;
            x_d      = x_q + COL_W'(1);
            k_d      = 2'd0;
            state_d  = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      row_d   = '0;
      col_d   = '0;
      rslot_d = 2'd0;
      dcol_d  = '0;
    end
  end

  assign inflight_d = inflight_q + {1'b0, mean_req_o.valid} - {1'b0, out_beat_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      state_q    <= ST_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      rslot_q    <= 2'd0;
      dcol_q     <= '0;
      second_q   <= 1'b0;
      k_q        <= 2'd0;
      tag_q      <= 1'b0;
      inflight_q <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_REG_W-1:0];
          REG_FRAME_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      rslot_q    <= rslot_d;
      dcol_q     <= dcol_d;
      second_q   <= second_d;
      k_q        <= k_d;
      tag_q      <= tag_d;
      inflight_q <= inflight_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    drain_q <= drain_d;
    top_q   <= top_d;
    mid_q   <= mid_d;
    bot_q   <= bot_d;
    top_v_q <= top_v_d;
    bot_v_q <= bot_v_d;
    acc_q   <= acc_d;
    ncols_q <= ncols_d;
  end

endmodule

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// box_blur_3x3_rgb: top level of the 3x3 RGB box blur
// ties the sequencer, the line store and the mean unit; depends on bb3_pkg
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  op_i, red_in_i, green_in_i, blue_in_i
//   out      out_valid_o/out_ready_i red/green/blue_out_o, row_end_o, frame_end_o
//   cfg      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// a beat with no result is taken in the idle state; a result adds three column reads
// through the single read port of the line store, a final accumulate step and a launch
// a launched result is registered in the product stage, then in the output queue
// reset clears counters and control registers; the data registers and the line store hold no reset state
// up to two results wait in the output queue; the sequencer stalls only at launch

module box_blur_3x3_rgb import bb3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [CHAN_W-1:0]     red_in_i,
  input  logic [CHAN_W-1:0]     green_in_i,
  input  logic [CHAN_W-1:0]     blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAN_W-1:0]     red_out_o,
  output logic [CHAN_W-1:0]     green_out_o,
  output logic [CHAN_W-1:0]     blue_out_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);

  mem_wr_t   mem_wr;
  mem_rd_t   mem_rd;
  col_t      mem_rd_data;
  mean_req_t mean_req;
  logic      out_beat;

  assign out_beat = out_valid_o && out_ready_i;

  bb3_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_beat_i    (out_beat),
    .mem_wr_o      (mem_wr),
    .mem_rd_o      (mem_rd),
    .mem_rd_data_i (mem_rd_data),
    .mean_req_o    (mean_req)
  );

  bb3_line_store u_line_store (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (mem_rd_data)
  );

  bb3_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mean_req),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== tb/tb_box_blur_3x3_rgb.sv =====
// tb_box_blur_3x3_rgb: self-checking testbench of the 3x3 rgb box blur, a typed
// directed table, a widest frame, then random frames, all beats checked against
// a line store model; depends on bb3_pkg and box_blur_3x3_rgb

module tb_box_blur_3x3_rgb import bb3_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_BEATS  = 280;
  localparam int unsigned WIDE_DRAINS = 64;
  localparam int unsigned SETTLE_CYC  = 32;
  localparam int unsigned HOLD_CYC    = 400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned REPORT_MAX  = 200;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              row_end;
    logic              frame_end;
  } blur_px_t;

  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] value;
    op_e                   op;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic                  typed;
    blur_px_t              want;
  } stim_row_t;

  localparam blur_px_t NO_WANT = '0;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  op_i        = 1'b0;
  logic [CHAN_W-1:0]     red_in_i    = '0;
  logic [CHAN_W-1:0]     green_in_i  = '0;
  logic [CHAN_W-1:0]     blue_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CHAN_W-1:0]     red_out_o;
  logic [CHAN_W-1:0]     green_out_o;
  logic [CHAN_W-1:0]     blue_out_o;
  logic                  row_end_o;
  logic                  frame_end_o;

  box_blur_3x3_rgb DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .red_in_i,
    .green_in_i,
    .blue_in_i,
    .out_valid_o,
    .out_ready_i,
    .red_out_o,
    .green_out_o,
    .blue_out_o,
    .row_end_o,
    .frame_end_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // blur model state
  pix_t                    line_mem    [SLOTS*MAX_WIDTH];
  bit                      line_filled [SLOTS*MAX_WIDTH];
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  int                      wr_row = 0;
  int                      wr_col = 0;
  int                      rd_col = 0;
  blur_px_t                blurred_due [$];
  int unsigned             beat_cnt = 0;

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned send_idle    = 0;
  int unsigned recv_idle    = 0;
  int unsigned stall_asked  = 0;
  int unsigned stall_taken  = 0;
  int unsigned hold_left    = 0;

  stim_row_t dir_tab [30] = '{
    '{1'b1, REG_FRAME_WIDTH,  13'd1, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b1, REG_FRAME_HEIGHT, 13'd1, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd170, 8'd85,  8'd15,  1'b1,
      '{8'd255, 8'd0, 8'd128, 1'b1, 1'b1}},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd255, 8'd1,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd255, 8'd255, 8'd255, 1'b1,
      '{8'd0, 8'd255, 8'd1, 1'b1, 1'b1}},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd0, 8'd255, 8'd1, 1'b1, 1'b1}},
    '{1'b1, REG_FRAME_WIDTH,  13'd2, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd1,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd128, 8'd1, 8'd0, 1'b0, 1'b0}},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd128, 8'd1, 8'd0, 1'b1, 1'b1}},
    '{1'b1, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b1, REG_FRAME_HEIGHT, 13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd7,   8'd8,   8'd9,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd7, 8'd8, 8'd9, 1'b1, 1'b1}},
    '{1'b1, REG_FRAME_WIDTH,  13'd3, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b1, REG_FRAME_HEIGHT, 13'd3, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd0,   8'd1,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd255, 8'd254, 1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd128, 8'd127, 8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd1,   8'd2,   8'd3,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd200, 8'd100, 8'd50,  1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd17,  8'd34,  8'd51,  1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd254, 8'd253, 8'd252, 1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b0, NO_WANT}
  };

  function automatic int act_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int act_height();
    if (height_reg == '0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic blur_px_t blur_pixel(input int y, input int x);
    int       w, h, ry, rx, cnt;
    int       sum_r, sum_g, sum_b;
    pix_t     v;
    blur_px_t res;
    w = act_width();
    h = act_height();
    cnt = 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        ry = y + dy;
        rx = x + dx;
        if (ry >= 0 && ry < h && rx >= 0 && rx < w) begin
          v = line_mem[(ry % SLOTS) * MAX_WIDTH + rx];
          sum_r += v[2*CHAN_W +: CHAN_W];
          sum_g += v[CHAN_W +: CHAN_W];
          sum_b += v[0 +: CHAN_W];
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    // exact round half up of sum / cnt
    res.red       = CHAN_W'((2 * sum_r + cnt) / (2 * cnt));
    res.green     = CHAN_W'((2 * sum_g + cnt) / (2 * cnt));
    res.blue      = CHAN_W'((2 * sum_b + cnt) / (2 * cnt));
    res.row_end   = (x == w - 1);
    res.frame_end = (x == w - 1) && (y == h - 1);
    return res;
  endfunction

  // a drain beat may only read store entries that were written at some point
  function automatic bit drain_safe();
    int w, h, x, ry, rx;
    w = act_width();
    h = act_height();
    x = (rd_col >= w) ? 0 : rd_col;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        ry = h - 1 + dy;
        rx = x + dx;
        if (ry >= 0 && ry < h && rx >= 0 && rx < w &&
            !line_filled[(ry % SLOTS) * MAX_WIDTH + rx]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_blur(input op_e op, input pix_t px, input logic typed,
                                       input blur_px_t want);
    int w, h, slot;
    w = act_width();
    h = act_height();
    beat_cnt++;
    if (op == OP_DRAIN) begin
      if (rd_col >= w) rd_col = 0;
      blurred_due.push_back(typed ? want : blur_pixel(h - 1, rd_col));
      rd_col = (rd_col + 1 >= w) ? 0 : rd_col + 1;
      return;
    end
    if (wr_col >= w) wr_col = 0;
    if (wr_row >= h) wr_row = 0;
    slot = (wr_row % SLOTS) * MAX_WIDTH + wr_col;
    line_mem[slot]    = px;
    line_filled[slot] = 1'b1;
    if (wr_row >= 1) begin
      if (wr_col >= 1) blurred_due.push_back(typed ? want : blur_pixel(wr_row - 1, wr_col - 1));
      if (wr_col == w - 1) blurred_due.push_back(typed ? want : blur_pixel(wr_row - 1, w - 1));
    end
    if (wr_col + 1 >= w) begin
      wr_col = 0;
      wr_row = (wr_row + 1 >= h) ? 0 : wr_row + 1;
    end else begin
      wr_col++;
    end
  endfunction

  function automatic pix_t rand_pix();
    pix_t px;
    for (int c = 0; c < CHANS; c++) begin
      case ($urandom_range(7))
        0:       px[c*CHAN_W +: CHAN_W] = '0;
        1:       px[c*CHAN_W +: CHAN_W] = '1;
        default: px[c*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(255));
      endcase
    end
    return px;
  endfunction

  task automatic offer_beat(input op_e op, input pix_t px, input logic typed = 1'b0,
                            input blur_px_t want = '0);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    red_in_i   <= px[2*CHAN_W +: CHAN_W];
    green_in_i <= px[CHAN_W +: CHAN_W];
    blue_in_i  <= px[0 +: CHAN_W];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_blur(op, px, typed, want);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (blurred_due.size() != 0) @(posedge clk_i);
  endtask

  // beats with no result may still be in flight when the queue runs dry
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = WIDTH_REG_W'(value);
    else height_reg = HEIGHT_REG_W'(value);
    wr_row = 0;
    wr_col = 0;
    rd_col = 0;
    @(posedge clk_i);
  endtask

  task automatic run_phase();
    int unsigned pick, wv, hv, frames, rows, npix, ndrain, w;
    settle();
    pick = $urandom_range(15);
    if (act_width() > 16) pick = 4;
    if (pick < 12) begin
      case ($urandom_range(9))
        0:       wv = 0;
        1, 2:    wv = $urandom_range(7, 16);
        default: wv = $urandom_range(1, 6);
      endcase
      write_reg(REG_FRAME_WIDTH, wv);
    end
    if (pick >= 4) begin
      case ($urandom_range(19))
        0:       hv = 0;
        1:       hv = 8191;
        2:       hv = MAX_HEIGHT;
        3, 4:    hv = $urandom_range(6, 10);
        default: hv = $urandom_range(1, 5);
      endcase
      write_reg(REG_FRAME_HEIGHT, hv);
    end
    w = act_width();
    rows = (act_height() > 16) ? 3 : act_height();
    frames = (act_height() > 16) ? 1 : $urandom_range(1, 3);
    repeat (frames) begin
      // mostly whole frames, now and then cut short
      npix = ($urandom_range(9) == 0) ? $urandom_range(1, w * rows) : w * rows;
      repeat (npix) begin
        if ($urandom_range(24) == 0 && drain_safe()) offer_beat(OP_DRAIN, rand_pix());
        if ($urandom_range(79) == 0) wait_results();
        offer_beat(OP_PIXEL, rand_pix());
      end
      ndrain = ($urandom_range(5) == 0) ? $urandom_range(0, 2 * w) : w;
      repeat (ndrain) begin
        if (drain_safe()) offer_beat(OP_DRAIN, rand_pix());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (stall_taken != stall_asked) begin
      out_ready_i <= 1'b0;
      stall_taken <= stall_asked;
      hold_left   <= HOLD_CYC;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    blur_px_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blurred_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
          $display("%0t: expected no beat, actual rgb %0d %0d %0d", $time,
                   red_out_o, green_out_o, blue_out_o);
        end
      end else begin
        want = blurred_due.pop_front();
        check_field("red_out", want.red, red_out_o);
        check_field("green_out", want.green, green_out_o);
        check_field("blue_out", want.blue, blue_out_o);
        check_field("row_end", want.row_end, row_end_o);
        check_field("frame_end", want.frame_end, frame_end_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rand_base;
    bit          mid_stall;
    mid_stall = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 13;
    recv_idle <= 79;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        offer_beat(dir_tab[i].op, {dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue},
                   dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // widest frame, one row, then drain its start while the receiver holds off
    settle();
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 0);
    repeat (MAX_WIDTH) offer_beat(OP_PIXEL, rand_pix());
    stall_asked <= stall_asked + 1;
    repeat (WIDE_DRAINS) begin
      if (drain_safe()) offer_beat(OP_DRAIN, rand_pix());
    end

    rand_base = beat_cnt;
    while (beat_cnt - rand_base < RAND_BEATS) begin
      if (beat_cnt - rand_base >= 2 * RAND_BEATS / 3) begin
        send_idle = 0;
        recv_idle <= 0;
      end else if (beat_cnt - rand_base >= RAND_BEATS / 3) begin
        send_idle = 79;
        recv_idle <= 13;
        if (!mid_stall) begin
          mid_stall = 1'b1;
          stall_asked <= stall_asked + 1;
        end
      end
      run_phase();
    end

    wait_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
